@@ rtl/core/ptwd_pkg.sv @@
// Package for the packed text word decoder: widths, result kinds, shift states,
// the alphabet and 8-bit character tables and the per-code decode function.
// No dependencies; every other file of the block uses this package.
package ptwd_pkg;

   localparam int WORD_W    = 16;
   localparam int CODE_W    = 10;
   localparam int KIND_W    = 2;
   localparam int ZC_W      = 5;
   localparam int NUM_SLOTS = 3;
   localparam int REP_W     = 2;
   localparam int END_BIT   = 15;

   typedef enum logic [KIND_W-1:0] {
      KIND_CHAR   = 2'd0,
      KIND_ABBREV = 2'd1,
      KIND_END    = 2'd2
   } kind_type;

   typedef enum logic [5:0] {
      SH_A0     = 6'b000001,
      SH_A1     = 6'b000010,
      SH_A2     = 6'b000100,
      SH_ABBREV = 6'b001000,
      SH_ESC_HI = 6'b010000,
      SH_ESC_LO = 6'b100000
   } shift_type;

   typedef struct packed {
      kind_type          kind;
      logic [CODE_W-1:0] code;
      logic [REP_W-1:0]  rep;
   } slot_type;

   typedef struct packed {
      slot_type [NUM_SLOTS-1:0] slot;
      logic                     fin;
   } group_type;

   typedef struct packed {
      slot_type        slot;
      shift_type       mode;
      logic [ZC_W-1:0] pend;
   } step_type;

   localparam logic [7:0] ALPHA2 [26] = '{
      8'd0, 8'd10, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56,
      8'd57, 8'd46, 8'd44, 8'd33, 8'd63, 8'd95, 8'd35, 8'd39, 8'd34, 8'd47, 8'd92,
      8'd45, 8'd58, 8'd40, 8'd41
   };

   // Unicode points for the 8-bit codes 155 to 223.
   localparam logic [CODE_W-1:0] ROM_HI [69] = '{
      10'h0e4, 10'h0f6, 10'h0fc, 10'h0c4, 10'h0d6, 10'h0dc, 10'h0df, 10'h0bb,
      10'h0ab, 10'h0eb, 10'h0ef, 10'h0ff, 10'h0cb, 10'h0cf, 10'h0e1, 10'h0e9,
      10'h0ed, 10'h0f3, 10'h0fa, 10'h0fd, 10'h0c1, 10'h0c9, 10'h0cd, 10'h0d3,
      10'h0da, 10'h0dd, 10'h0e0, 10'h0e8, 10'h0ec, 10'h0f2, 10'h0f9, 10'h0c0,
      10'h0c8, 10'h0cc, 10'h0d2, 10'h0d9, 10'h0e2, 10'h0ea, 10'h0ee, 10'h0f4,
      10'h0fb, 10'h0c2, 10'h0ca, 10'h0ce, 10'h0d4, 10'h0db, 10'h0e5, 10'h0c5,
      10'h0f8, 10'h0d8, 10'h0e3, 10'h0f1, 10'h0f5, 10'h0c3, 10'h0d1, 10'h0d5,
      10'h0e6, 10'h0c6, 10'h0e7, 10'h0c7, 10'h0fe, 10'h0f0, 10'h0de, 10'h0d0,
      10'h0a3, 10'h153, 10'h152, 10'h0a1, 10'h0bf
   };

   localparam logic [CODE_W-1:0] CH_TAB     = 10'h009;
   localparam logic [CODE_W-1:0] CH_NEWLINE = 10'h00a;
   localparam logic [CODE_W-1:0] CH_SPACE   = 10'h020;
   localparam logic [CODE_W-1:0] CH_UNKNOWN = 10'h03f;

   function automatic logic [CODE_W-1:0] rom_lookup(input logic [7:0] z);
      logic [7:0]        idx;
      logic [CODE_W-1:0] u;
      idx = z - 8'd155;
      if (z == 8'd9) begin
         u = CH_TAB;
      end else if (z == 8'd10 || z == 8'd13) begin
         u = CH_NEWLINE;
      end else if (z == 8'd11) begin
         u = CH_SPACE;
      end else if (z >= 8'd32 && z <= 8'd127) begin
         u = {2'b00, z};
      end else if (z >= 8'd155 && z <= 8'd223) begin
         u = ROM_HI[idx[6:0]];
      end else begin
         u = CH_UNKNOWN;
      end
      return u;
   endfunction

   // A tab becomes three spaces, every other character one result.
   function automatic slot_type char8(input logic [7:0] z);
      slot_type          s;
      logic [CODE_W-1:0] u;
      u = rom_lookup(z);
      s.kind = KIND_CHAR;
      if (u == CH_TAB) begin
         s.code = CH_SPACE;
         s.rep  = 2'd3;
      end else begin
         s.code = u;
         s.rep  = 2'd1;
      end
      return s;
   endfunction

   function automatic step_type do_code(input shift_type mode, input logic [ZC_W-1:0] pend,
                                        input logic [ZC_W-1:0] c);
      step_type        r;
      logic [9:0]      z;
      logic [ZC_W-1:0] idx;
      idx         = c - 5'd6;
      z           = {pend, c};
      r.slot.kind = KIND_CHAR;
      r.slot.code = '0;
      r.slot.rep  = '0;
      r.mode      = mode;
      r.pend      = pend;
      case (mode)
         SH_ABBREV: begin
            r.slot.kind = KIND_ABBREV;
            r.slot.code = {3'b000, pend[1:0], c};
            r.slot.rep  = 2'd1;
            r.mode      = SH_A0;
         end
         SH_ESC_HI: begin
            r.pend = c;
            r.mode = SH_ESC_LO;
         end
         SH_ESC_LO: begin
            r.mode = SH_A0;
            if (z[9:8] == 2'b00) begin
               r.slot = char8(z[7:0]);
            end else begin
               r.slot.code = z;
               r.slot.rep  = 2'd1;
            end
         end
         default: begin
            if (mode == SH_A2 && c == 5'd6) begin
               r.mode = SH_ESC_HI;
            end else if (c >= 5'd6) begin
               r.mode = SH_A0;
               if (mode == SH_A1) begin
                  r.slot = char8(8'd65 + {3'b000, idx});
               end else if (mode == SH_A2) begin
                  r.slot = char8(ALPHA2[idx]);
               end else begin
                  r.slot = char8(8'd97 + {3'b000, idx});
               end
            end else begin
               case (c)
                  5'd0: begin
                     r.slot.code = CH_SPACE;
                     r.slot.rep  = 2'd1;
                     r.mode      = SH_A0;
                  end
                  5'd1, 5'd2, 5'd3: begin
                     r.pend = c - 5'd1;
                     r.mode = SH_ABBREV;
                  end
                  5'd4: begin
                     r.mode = SH_A1;
                  end
                  default: begin
                     r.mode = SH_A2;
                  end
               endcase
            end
         end
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/ptwd_if.sv @@
// Valid/ready channel interfaces of the packed text word decoder:
// the packed word input channel and the decoded result channel. Uses ptwd_pkg.
interface ptwd_req_if;
   logic                         valid;
   logic                         ready;
   logic [ptwd_pkg::WORD_W-1:0]  packed_word;

   modport source (output valid, output packed_word, input ready);
   modport sink   (input valid, input packed_word, output ready);
endinterface

interface ptwd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ptwd_pkg::KIND_W-1:0]  kind;
   logic [ptwd_pkg::CODE_W-1:0]  code;
   logic                         last;
   logic                         string_end;

   modport source (output valid, output kind, output code, output last, output string_end,
                   input ready);
   modport sink   (input valid, input kind, input code, input last, input string_end,
                   output ready);
endinterface

@@ rtl/core/ptwd_decode.sv @@
// Input register, shift state and three-code decode of one packed text word.
// Depends on ptwd_pkg and the ptwd_req_if interface.
module ptwd_decode (
   input  logic                clock,
   input  logic                reset,
   ptwd_req_if.sink            req_if,
   output ptwd_pkg::group_type group,
   output logic                group_valid,
   input  logic                group_ready
);

   logic [ptwd_pkg::WORD_W-1:0] word_ff;
   logic                        valid_ff;
   logic                        valid_in;
   ptwd_pkg::shift_type         mode_ff;
   ptwd_pkg::shift_type         mode_in;
   logic [ptwd_pkg::ZC_W-1:0]   pend_ff;
   logic [ptwd_pkg::ZC_W-1:0]   pend_in;
   ptwd_pkg::step_type          step0;
   ptwd_pkg::step_type          step1;
   ptwd_pkg::step_type          step2;
   logic                        fin;
   logic                        none;
   logic                        needs;
   logic                        fire;

   assign fin   = word_ff[ptwd_pkg::END_BIT];
   assign step0 = ptwd_pkg::do_code(mode_ff, pend_ff, word_ff[14:10]);
   assign step1 = ptwd_pkg::do_code(step0.mode, step0.pend, word_ff[9:5]);
   assign step2 = ptwd_pkg::do_code(step1.mode, step1.pend, word_ff[4:0]);
   assign none  = (step0.slot.rep == '0) && (step1.slot.rep == '0) && (step2.slot.rep == '0);

   always_comb begin
      group.slot[0] = step0.slot;
      group.slot[1] = step1.slot;
      group.slot[2] = step2.slot;
      group.fin     = fin;
      if (none && fin) begin
         group.slot[0].kind = ptwd_pkg::KIND_END;
         group.slot[0].code = '0;
         group.slot[0].rep  = 2'd1;
      end
   end

   assign needs         = !none || fin;
   assign group_valid   = valid_ff && needs;
   assign fire          = valid_ff && (!needs || group_ready);
   assign req_if.ready  = !valid_ff || fire;
   assign valid_in      = req_if.valid || (valid_ff && !fire);
   assign mode_in       = fin ? ptwd_pkg::SH_A0 : step2.mode;
   assign pend_in       = fin ? '0 : step2.pend;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         mode_ff  <= ptwd_pkg::SH_A0;
         pend_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         if (fire) begin
            mode_ff <= mode_in;
            pend_ff <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         word_ff <= req_if.packed_word;
      end
   end

   // The end flag always leaves the decoder in alphabet zero with nothing pending.
   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      fire && fin |=> mode_ff == ptwd_pkg::SH_A0 && pend_ff == '0)
      else $error("shift state not cleared after end of string");

endmodule

@@ rtl/core/ptwd_emit.sv @@
// Result buffer for one decoded word and the emitter that sends its results one
// per cycle while the output is ready. Depends on ptwd_pkg and the ptwd_rsp_if interface.
module ptwd_emit (
   input  logic                clock,
   input  logic                reset,
   input  ptwd_pkg::group_type group,
   input  logic                group_valid,
   output logic                group_ready,
   ptwd_rsp_if.source          rsp_if
);

   ptwd_pkg::group_type        group_ff;
   logic [ptwd_pkg::REP_W-1:0] rep_ff [ptwd_pkg::NUM_SLOTS];
   logic [ptwd_pkg::REP_W-1:0] rep_in [ptwd_pkg::NUM_SLOTS];
   logic [1:0]                 sel;
   logic [3:0]                 total;
   logic                       last;
   logic                       take;
   logic                       load;

   always_comb begin
      if (rep_ff[0] != '0) begin
         sel = 2'd0;
      end else if (rep_ff[1] != '0) begin
         sel = 2'd1;
      end else begin
         sel = 2'd2;
      end
   end

   assign total = {2'b00, rep_ff[0]} + {2'b00, rep_ff[1]} + {2'b00, rep_ff[2]};
   assign last  = (total == 4'd1);
   assign take  = rsp_if.valid && rsp_if.ready;
   assign group_ready = !rsp_if.valid || (take && last);
   assign load  = group_valid && group_ready;

   assign rsp_if.valid      = (total != 4'd0);
   assign rsp_if.kind       = group_ff.slot[sel].kind;
   assign rsp_if.code       = group_ff.slot[sel].code;
   assign rsp_if.last       = last;
   assign rsp_if.string_end = last && group_ff.fin;

   always_comb begin
      for (int i = 0; i < ptwd_pkg::NUM_SLOTS; i++) begin
         if (load) begin
            rep_in[i] = group.slot[i].rep;
         end else if (take && sel == 2'(i)) begin
            rep_in[i] = rep_ff[i] - 2'd1;
         end else begin
            rep_in[i] = rep_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ptwd_pkg::NUM_SLOTS; i++) begin
            rep_ff[i] <= '0;
         end
      end else begin
         rep_ff <= rep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         group_ff <= group;
      end
   end

   a_end_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.kind == ptwd_pkg::KIND_END |-> last && rsp_if.string_end)
      else $error("end marker not the last result of an end word");

   a_abbrev_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.kind == ptwd_pkg::KIND_ABBREV |-> rsp_if.code < 10'd96)
      else $error("abbreviation index out of range");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_if.valid)
      else $error("loaded word gives no result");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      take && last && !group_valid |=> !rsp_if.valid)
      else $error("result buffer not empty after its last result");

endmodule

@@ rtl/core/packed_text_word_decoder.sv @@
// Top level of the packed text word decoder: the decode stage feeding the
// result emitter. Depends on ptwd_pkg, ptwd_if, ptwd_decode and ptwd_emit.
//
//   Channel  Dir  Payload                         Handshake
//   req_if   in   packed_word[15:0]               valid/ready
//   rsp_if   out  kind[1:0] code[9:0] last s_end  valid/ready
//
// A word is registered, then decoded combinationally into a buffer of up to nine results.
// Results leave one per cycle while rsp_if.ready is high; the single-result output port
// sets that pace, and the next word waits in the input register while the buffer drains.
// Reset is synchronous and returns the shift state to alphabet zero.
module packed_text_word_decoder (
   input  logic         clock,
   input  logic         reset,
   ptwd_req_if.sink     req_if,
   ptwd_rsp_if.source   rsp_if
);

   ptwd_pkg::group_type group;
   logic                group_valid;
   logic                group_ready;

   ptwd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .group       (group),
      .group_valid (group_valid),
      .group_ready (group_ready)
   );

   ptwd_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .group       (group),
      .group_valid (group_valid),
      .group_ready (group_ready),
      .rsp_if      (rsp_if)
   );

endmodule

@@ verif/tb_packed_text_word_decoder.sv @@
// Testbench for packed_text_word_decoder: drives packed text words with random gaps,
// predicts the decoded characters, abbreviation requests and end markers, and checks them.
// Depends on ptwd_pkg, ptwd_if and the decoder RTL.
`timescale 1ns / 100ps

module tb_packed_text_word_decoder;

   typedef enum logic [5:0] {
      ST_A0     = 6'b000001,
      ST_A1     = 6'b000010,
      ST_A2     = 6'b000100,
      ST_ABBREV = 6'b001000,
      ST_ESC_HI = 6'b010000,
      ST_ESC_LO = 6'b100000
   } text_state_type;

   typedef struct {
      ptwd_pkg::kind_type          kind;
      logic [ptwd_pkg::CODE_W-1:0] code;
      logic                        last;
      logic                        string_end;
   } glyph_type;

   localparam logic [7:0] PUNCT_A2 [26] = '{
      8'd0, 8'd10, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56,
      8'd57, 8'd46, 8'd44, 8'd33, 8'd63, 8'd95, 8'd35, 8'd39, 8'd34, 8'd47, 8'd92,
      8'd45, 8'd58, 8'd40, 8'd41
   };

   localparam logic [9:0] HI_LATIN [69] = '{
      10'h0e4, 10'h0f6, 10'h0fc, 10'h0c4, 10'h0d6, 10'h0dc, 10'h0df, 10'h0bb,
      10'h0ab, 10'h0eb, 10'h0ef, 10'h0ff, 10'h0cb, 10'h0cf, 10'h0e1, 10'h0e9,
      10'h0ed, 10'h0f3, 10'h0fa, 10'h0fd, 10'h0c1, 10'h0c9, 10'h0cd, 10'h0d3,
      10'h0da, 10'h0dd, 10'h0e0, 10'h0e8, 10'h0ec, 10'h0f2, 10'h0f9, 10'h0c0,
      10'h0c8, 10'h0cc, 10'h0d2, 10'h0d9, 10'h0e2, 10'h0ea, 10'h0ee, 10'h0f4,
      10'h0fb, 10'h0c2, 10'h0ca, 10'h0ce, 10'h0d4, 10'h0db, 10'h0e5, 10'h0c5,
      10'h0f8, 10'h0d8, 10'h0e3, 10'h0f1, 10'h0f5, 10'h0c3, 10'h0d1, 10'h0d5,
      10'h0e6, 10'h0c6, 10'h0e7, 10'h0c7, 10'h0fe, 10'h0f0, 10'h0de, 10'h0d0,
      10'h0a3, 10'h153, 10'h152, 10'h0a1, 10'h0bf
   };

   logic clock;
   logic reset;

   ptwd_req_if req_if();
   ptwd_rsp_if rsp_if();

   packed_text_word_decoder i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   logic [ptwd_pkg::WORD_W-1:0] word_q[$];
   logic [4:0]                  code_stream[$];
   glyph_type                   glyphs_due[$];
   glyph_type                   fresh[$];
   text_state_type              text_state = ST_A0;
   logic [4:0]                  held_bits = '0;
   int                          mismatches = 0;
   int                          word_gap = 0;
   int                          rsp_stall = 0;
   bit                          req_quiet = 1'b0;
   bit                          rsp_quiet = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_error(input string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [9:0] unicode_of(input logic [7:0] z);
      logic [7:0] off;
      off = z - 8'd155;
      if (z == 8'd9) return 10'd9;
      if (z == 8'd10 || z == 8'd13) return 10'd10;
      if (z == 8'd11) return 10'h20;
      if (z >= 8'd32 && z <= 8'd127) return {2'b00, z};
      if (z >= 8'd155 && z <= 8'd223) return HI_LATIN[off[6:0]];
      return 10'h3f;
   endfunction

   task automatic add_glyph(input ptwd_pkg::kind_type kind, input logic [9:0] code);
      glyph_type g;
      g.kind       = kind;
      g.code       = code;
      g.last       = 1'b0;
      g.string_end = 1'b0;
      fresh.push_back(g);
   endtask

   task automatic add_char8(input logic [7:0] z);
      logic [9:0] u;
      u = unicode_of(z);
      if (u == 10'd9) begin
         repeat (3) add_glyph(ptwd_pkg::KIND_CHAR, 10'h20);
      end else begin
         add_glyph(ptwd_pkg::KIND_CHAR, u);
      end
   endtask

   task automatic decode_code(input logic [4:0] c);
      logic [9:0] z;
      z = {held_bits, c};
      case (text_state)
         ST_ABBREV: begin
            add_glyph(ptwd_pkg::KIND_ABBREV, {3'b000, held_bits[1:0], c});
            text_state = ST_A0;
         end
         ST_ESC_HI: begin
            held_bits  = c;
            text_state = ST_ESC_LO;
         end
         ST_ESC_LO: begin
            text_state = ST_A0;
            if (z < 10'd256) add_char8(z[7:0]);
            else add_glyph(ptwd_pkg::KIND_CHAR, z);
         end
         default: begin
            if (text_state == ST_A2 && c == 5'd6) begin
               text_state = ST_ESC_HI;
            end else if (c >= 5'd6) begin
               if (text_state == ST_A1) add_char8(8'd65 + 8'(c - 5'd6));
               else if (text_state == ST_A2) add_char8(PUNCT_A2[c - 5'd6]);
               else add_char8(8'd97 + 8'(c - 5'd6));
               text_state = ST_A0;
            end else if (c == 5'd0) begin
               add_glyph(ptwd_pkg::KIND_CHAR, 10'h20);
               text_state = ST_A0;
            end else if (c <= 5'd3) begin
               held_bits  = c - 5'd1;
               text_state = ST_ABBREV;
            end else if (c == 5'd4) begin
               text_state = ST_A1;
            end else begin
               text_state = ST_A2;
            end
         end
      endcase
   endtask

   task automatic decode_word(input logic [ptwd_pkg::WORD_W-1:0] w);
      fresh.delete();
      decode_code(w[14:10]);
      decode_code(w[9:5]);
      decode_code(w[4:0]);
      if (w[ptwd_pkg::END_BIT]) begin
         text_state = ST_A0;
         held_bits  = '0;
         if (fresh.size() == 0) add_glyph(ptwd_pkg::KIND_END, '0);
      end
      if (fresh.size() != 0) begin
         fresh[fresh.size() - 1].last       = 1'b1;
         fresh[fresh.size() - 1].string_end = w[ptwd_pkg::END_BIT];
      end
      foreach (fresh[i]) glyphs_due.push_back(fresh[i]);
   endtask

   function automatic logic [ptwd_pkg::WORD_W-1:0] pack_word(input bit fin,
                                                             input logic [4:0] a,
                                                             input logic [4:0] b,
                                                             input logic [4:0] c);
      return {fin, a, b, c};
   endfunction

   task automatic add_token();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         code_stream.push_back(5'($urandom_range(6, 31)));
      end else if (r < 50) begin
         code_stream.push_back(5'd0);
      end else if (r < 62) begin
         code_stream.push_back(5'($urandom_range(4, 5)));
         code_stream.push_back(5'($urandom_range(0, 31)));
      end else if (r < 74) begin
         code_stream.push_back(5'($urandom_range(1, 3)));
         code_stream.push_back(5'($urandom_range(0, 31)));
      end else if (r < 92) begin
         code_stream.push_back(5'd5);
         code_stream.push_back(5'd6);
         if ($urandom_range(0, 7) == 0) begin
            code_stream.push_back(5'd0);
            code_stream.push_back(5'd9);
         end else begin
            code_stream.push_back(5'($urandom_range(0, 1) ? $urandom_range(0, 7)
                                                           : $urandom_range(0, 31)));
            code_stream.push_back(5'($urandom_range(0, 31)));
         end
      end else begin
         code_stream.push_back(5'($urandom_range(0, 31)));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         word_gap     <= 0;
      end else begin
         if (req_if.valid && req_if.ready) decode_word(req_if.packed_word);
         if (!req_if.valid || req_if.ready) begin
            if (word_gap != 0) begin
               req_if.valid <= 1'b0;
               word_gap     <= word_gap - 1;
            end else if (word_q.size() != 0) begin
               req_if.valid       <= 1'b1;
               req_if.packed_word <= word_q.pop_front();
               word_gap           <= pick_gap(req_quiet);
               if ($urandom_range(0, 29) == 0) req_quiet <= !req_quiet;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_side
      glyph_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (glyphs_due.size() == 0) begin
               report_error($sformatf("unexpected result kind %0d code %0h",
                                      rsp_if.kind, rsp_if.code));
            end else begin
               want = glyphs_due.pop_front();
               if (rsp_if.kind !== want.kind || rsp_if.code !== want.code ||
                   rsp_if.last !== want.last || rsp_if.string_end !== want.string_end) begin
                  report_error($sformatf("got kind %0d code %0h last %b end %b, want %0d %0h %b %b",
                                         rsp_if.kind, rsp_if.code, rsp_if.last,
                                         rsp_if.string_end, want.kind, want.code, want.last,
                                         want.string_end));
               end
            end
         end
         if (rsp_stall != 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall    <= rsp_stall - 1;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_stall <= pick_gap(rsp_quiet);
            if ($urandom_range(0, 39) == 0) rsp_quiet <= !rsp_quiet;
         end
      end
   end

   initial begin
      int               drain;
      logic [4:0]       a;
      logic [4:0]       b;
      logic [4:0]       c;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.packed_word = '0;
      rsp_if.ready       = 1'b0;

      word_q.push_back(pack_word(1'b0, 5'd0, 5'd0, 5'd0));
      word_q.push_back(pack_word(1'b1, 5'd31, 5'd31, 5'd31));
      word_q.push_back(pack_word(1'b0, 5'd6, 5'd4, 5'd6));
      word_q.push_back(pack_word(1'b0, 5'd4, 5'd31, 5'd0));
      word_q.push_back(pack_word(1'b0, 5'd5, 5'd7, 5'd5));
      word_q.push_back(pack_word(1'b0, 5'd31, 5'd5, 5'd6));
      word_q.push_back(pack_word(1'b0, 5'd0, 5'd9, 5'd5));
      word_q.push_back(pack_word(1'b0, 5'd6, 5'd8, 5'd0));
      word_q.push_back(pack_word(1'b0, 5'd5, 5'd6, 5'd31));
      word_q.push_back(pack_word(1'b0, 5'd31, 5'd5, 5'd6));
      word_q.push_back(pack_word(1'b0, 5'd4, 5'd27, 5'd5));
      word_q.push_back(pack_word(1'b0, 5'd6, 5'd6, 5'd28));
      word_q.push_back(pack_word(1'b0, 5'd5, 5'd6, 5'd0));
      word_q.push_back(pack_word(1'b0, 5'd0, 5'd5, 5'd6));
      word_q.push_back(pack_word(1'b0, 5'd0, 5'd13, 5'd5));
      word_q.push_back(pack_word(1'b0, 5'd6, 5'd0, 5'd11));
      word_q.push_back(pack_word(1'b0, 5'd1, 5'd0, 5'd3));
      word_q.push_back(pack_word(1'b0, 5'd31, 5'd2, 5'd15));
      word_q.push_back(pack_word(1'b1, 5'd4, 5'd5, 5'd4));
      word_q.push_back(pack_word(1'b1, 5'd5, 5'd6, 5'd3));
      word_q.push_back(pack_word(1'b0, 5'd6, 5'd6, 5'd6));
      word_q.push_back(pack_word(1'b1, 5'd0, 5'd0, 5'd1));
      word_q.push_back(pack_word(1'b0, 5'd6, 5'd0, 5'd0));
      word_q.push_back(pack_word(1'b0, 5'd5, 5'd6, 5'd4));
      word_q.push_back(pack_word(1'b0, 5'd0, 5'd0, 5'd0));

      // Mostly well-formed code streams, with raw noise words mixed in.
      for (int n = 0; n < 95; n++) begin
         if ($urandom_range(0, 7) == 0) begin
            word_q.push_back(ptwd_pkg::WORD_W'($urandom_range(0, 65535)));
         end else begin
            while (code_stream.size() < 3) add_token();
            a = code_stream.pop_front();
            b = code_stream.pop_front();
            c = code_stream.pop_front();
            word_q.push_back(pack_word($urandom_range(0, 5) == 0, a, b, c));
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (word_q.size() != 0 || req_if.valid || glyphs_due.size() != 0) @(posedge clock);
      for (drain = 0; drain < 20; drain++) @(posedge clock);

      if (mismatches == 0 && glyphs_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
